// ===== hdl/sbt_pkg.sv =====
package sbt_pkg;

	localparam int FIELD_POS_BITS  = 20;
	localparam int FIELD_LINE_BITS = 16;
	localparam int KIND_BITS       = 5;
	localparam int MAX_TOKENS      = 4;
	localparam int COUNT_BITS      = $clog2(MAX_TOKENS + 1);
	localparam int QUEUE_DEPTH     = 4;
	localparam int WIDE_BITS       = 33;

	localparam logic [FIELD_POS_BITS-1:0]  FIELD_POS_MAX  = '1;
	localparam logic [FIELD_LINE_BITS-1:0] FIELD_LINE_MAX = '1;

	// lexer modes
	typedef enum logic [3:0] {
		M_IDLE, M_BANG, M_EQUAL, M_GREATER, M_LESS, M_SLASH, M_COMMENT,
		M_STRING, M_NUMBER, M_NUMDOT, M_FRACTION, M_IDENT
	} mode_t;

	// token kinds
	localparam logic [KIND_BITS-1:0] K_LPAREN        = 5'd0;
	localparam logic [KIND_BITS-1:0] K_RPAREN        = 5'd1;
	localparam logic [KIND_BITS-1:0] K_LBRACE        = 5'd2;
	localparam logic [KIND_BITS-1:0] K_RBRACE        = 5'd3;
	localparam logic [KIND_BITS-1:0] K_COMMA         = 5'd4;
	localparam logic [KIND_BITS-1:0] K_DOT           = 5'd5;
	localparam logic [KIND_BITS-1:0] K_MINUS         = 5'd6;
	localparam logic [KIND_BITS-1:0] K_PLUS          = 5'd7;
	localparam logic [KIND_BITS-1:0] K_SEMICOLON     = 5'd8;
	localparam logic [KIND_BITS-1:0] K_SLASH         = 5'd9;
	localparam logic [KIND_BITS-1:0] K_STAR          = 5'd10;
	localparam logic [KIND_BITS-1:0] K_BANG          = 5'd11;
	localparam logic [KIND_BITS-1:0] K_EQUAL         = 5'd13;
	localparam logic [KIND_BITS-1:0] K_GREATER       = 5'd15;
	localparam logic [KIND_BITS-1:0] K_LESS          = 5'd17;
	localparam logic [KIND_BITS-1:0] K_IDENT         = 5'd19;
	localparam logic [KIND_BITS-1:0] K_STRING        = 5'd20;
	localparam logic [KIND_BITS-1:0] K_NUMBER        = 5'd21;
	localparam logic [KIND_BITS-1:0] K_END           = 5'd22;
	localparam logic [KIND_BITS-1:0] K_BADCHAR       = 5'd23;
	localparam logic [KIND_BITS-1:0] K_UNTERM        = 5'd24;
	localparam logic [KIND_BITS-1:0] K_PAIR_STEP     = 5'd1;

	// source characters
	localparam logic [7:0] CH_LPAREN  = 8'h28;
	localparam logic [7:0] CH_RPAREN  = 8'h29;
	localparam logic [7:0] CH_LBRACE  = 8'h7B;
	localparam logic [7:0] CH_RBRACE  = 8'h7D;
	localparam logic [7:0] CH_COMMA   = 8'h2C;
	localparam logic [7:0] CH_DOT     = 8'h2E;
	localparam logic [7:0] CH_MINUS   = 8'h2D;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_SEMI    = 8'h3B;
	localparam logic [7:0] CH_STAR    = 8'h2A;
	localparam logic [7:0] CH_BANG    = 8'h21;
	localparam logic [7:0] CH_EQUAL   = 8'h3D;
	localparam logic [7:0] CH_GREATER = 8'h3E;
	localparam logic [7:0] CH_LESS    = 8'h3C;
	localparam logic [7:0] CH_SLASH   = 8'h2F;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_CR      = 8'h0D;
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_NL      = 8'h0A;
	localparam logic [7:0] CH_QUOTE   = 8'h22;
	localparam logic [7:0] CH_UNDER   = 8'h5F;

	typedef struct packed {
		logic [7:0] source_byte;
		logic       final_byte;
	} src_item_t;

	typedef struct packed {
		logic [KIND_BITS-1:0]       token_kind;
		logic [FIELD_POS_BITS-1:0]  token_start;
		logic [FIELD_POS_BITS-1:0]  token_length;
		logic [FIELD_LINE_BITS-1:0] token_line;
		logic                       run_end;
	} tok_item_t;

	// all tokens one byte causes, in order
	typedef struct packed {
		logic [COUNT_BITS-1:0]           count;
		tok_item_t [MAX_TOKENS-1:0]      tok;
	} tok_bundle_t;

	typedef struct packed {
		logic full;
		logic not_empty;
	} q_status_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A))
			|| (c == CH_UNDER);
	endfunction

	function automatic logic [FIELD_POS_BITS-1:0] clip_pos(input logic [WIDE_BITS-1:0] v);
		return (v > WIDE_BITS'(FIELD_POS_MAX)) ? FIELD_POS_MAX : v[FIELD_POS_BITS-1:0];
	endfunction

	function automatic logic [FIELD_LINE_BITS-1:0] clip_line(input logic [31:0] v);
		return (v > 32'(FIELD_LINE_MAX)) ? FIELD_LINE_MAX : v[FIELD_LINE_BITS-1:0];
	endfunction

	function automatic logic [WIDE_BITS-1:0] sub_sat(input logic [WIDE_BITS-1:0] a,
			input logic [WIDE_BITS-1:0] b);
		return (a > b) ? a - b : '0;
	endfunction

	function automatic logic [KIND_BITS-1:0] op_kind(input mode_t m);
		logic [KIND_BITS-1:0] k;
		unique case (m)
			M_BANG:    k = K_BANG;
			M_EQUAL:   k = K_EQUAL;
			M_GREATER: k = K_GREATER;
			default:   k = K_LESS;
		endcase
		return k;
	endfunction

	// single-character punctuation: {hit, kind}
	function automatic logic [KIND_BITS:0] punct_lookup(input logic [7:0] c);
		logic [KIND_BITS:0] r;
		unique case (c)
			CH_LPAREN: r = {1'b1, K_LPAREN};
			CH_RPAREN: r = {1'b1, K_RPAREN};
			CH_LBRACE: r = {1'b1, K_LBRACE};
			CH_RBRACE: r = {1'b1, K_RBRACE};
			CH_COMMA:  r = {1'b1, K_COMMA};
			CH_DOT:    r = {1'b1, K_DOT};
			CH_MINUS:  r = {1'b1, K_MINUS};
			CH_PLUS:   r = {1'b1, K_PLUS};
			CH_SEMI:   r = {1'b1, K_SEMICOLON};
			CH_STAR:   r = {1'b1, K_STAR};
			default:   r = '0;
		endcase
		return r;
	endfunction

endpackage

// ===== hdl/sbt_front.sv =====
module sbt_front #(
	parameter int POSITION_BITS = 20,
	parameter int LINE_BITS     = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               src_valid,
	output logic               src_stall,
	input  sbt_pkg::src_item_t src_item,
	input  sbt_pkg::q_status_t q_stat,
	output logic               push,
	output sbt_pkg::tok_bundle_t bundle
);
	import sbt_pkg::*;

	typedef struct packed {
		logic [1:0] n;
		tok_item_t  t0;
		tok_item_t  t1;
	} close_t;

	mode_t                    mode_q, mode_d;
	logic [POSITION_BITS-1:0] pos_q, pos_d;
	logic [POSITION_BITS-1:0] begin_q, begin_d;
	logic [LINE_BITS-1:0]     line_q, line_d;
	logic                     accept;

	function automatic tok_item_t mk(input logic [KIND_BITS-1:0] k,
			input logic [WIDE_BITS-1:0] s, input logic [WIDE_BITS-1:0] l,
			input logic [LINE_BITS-1:0] ln);
		tok_item_t r;
		r.token_kind   = k;
		r.token_start  = clip_pos(s);
		r.token_length = clip_pos(l);
		r.token_line   = clip_line(32'(ln));
		r.run_end      = 1'b0;
		return r;
	endfunction

	function automatic logic [LINE_BITS-1:0] line_inc(input logic [LINE_BITS-1:0] ln);
		return (ln != '1) ? ln + 1'b1 : ln;
	endfunction

	// tokens a pending mode yields when its text ends just before offset e
	function automatic close_t close_tokens(input mode_t m, input logic [POSITION_BITS-1:0] b,
			input logic [POSITION_BITS-1:0] e, input logic [LINE_BITS-1:0] ln);
		close_t                   r;
		logic [POSITION_BITS:0]   b1;
		logic [POSITION_BITS-1:0] dp;
		r  = '0;
		b1 = {1'b0, b} + 1'b1;
		dp = (e != '0) ? e - 1'b1 : '0;
		unique case (m)
			M_BANG, M_EQUAL, M_GREATER, M_LESS: begin
				r.n  = 2'd1;
				r.t0 = mk(op_kind(m), WIDE_BITS'(b), WIDE_BITS'(1), ln);
			end
			M_SLASH: begin
				r.n  = 2'd1;
				r.t0 = mk(K_SLASH, WIDE_BITS'(b), WIDE_BITS'(1), ln);
			end
			M_STRING: begin
				r.n  = 2'd1;
				r.t0 = mk(K_UNTERM, WIDE_BITS'(b1),
					sub_sat(WIDE_BITS'(e), WIDE_BITS'(b1)), ln);
			end
			M_NUMBER, M_FRACTION: begin
				r.n  = 2'd1;
				r.t0 = mk(K_NUMBER, WIDE_BITS'(b), sub_sat(WIDE_BITS'(e), WIDE_BITS'(b)), ln);
			end
			M_NUMDOT: begin
				r.n  = 2'd2;
				r.t0 = mk(K_NUMBER, WIDE_BITS'(b), sub_sat(WIDE_BITS'(dp), WIDE_BITS'(b)), ln);
				r.t1 = mk(K_DOT, WIDE_BITS'(dp), WIDE_BITS'(1), ln);
			end
			M_IDENT: begin
				r.n  = 2'd1;
				r.t0 = mk(K_IDENT, WIDE_BITS'(b), sub_sat(WIDE_BITS'(e), WIDE_BITS'(b)), ln);
			end
			default: begin
				r.n = 2'd0;
			end
		endcase
		return r;
	endfunction

	// accept a byte whenever the queue has room for its tokens
	assign src_stall = q_stat.full;
	assign accept    = src_valid && !src_stall;
	assign push      = accept && (bundle.count != '0);

	// classify one byte: close, start, and end-of-source tokens in order
	always_comb begin
		logic [7:0]               c;
		logic                     fin;
		logic                     done;
		logic                     close_now;
		logic [KIND_BITS:0]       pk;
		mode_t                    m;
		logic [POSITION_BITS-1:0] b;
		logic [POSITION_BITS-1:0] p;
		logic [POSITION_BITS-1:0] pn;
		logic [POSITION_BITS:0]   b1;
		logic [LINE_BITS-1:0]     ln;
		logic [COUNT_BITS-1:0]    n;
		tok_item_t [MAX_TOKENS-1:0] tk;
		close_t                   cl;

		c         = src_item.source_byte;
		fin       = src_item.final_byte;
		m         = mode_q;
		b         = begin_q;
		p         = pos_q;
		ln        = line_q;
		b1        = {1'b0, begin_q} + 1'b1;
		n         = '0;
		tk        = '0;
		done      = 1'b0;
		close_now = 1'b0;
		pk        = '0;
		cl        = '0;

		// continue the pending token
		unique case (m)
			M_BANG, M_EQUAL, M_GREATER, M_LESS: begin
				if (c == CH_EQUAL) begin
					tk[n[1:0]] = mk(op_kind(m) + K_PAIR_STEP, WIDE_BITS'(b),
						WIDE_BITS'(2), ln);
					n    = n + 1'b1;
					m    = M_IDLE;
					done = 1'b1;
				end else begin
					close_now = 1'b1;
				end
			end
			M_SLASH: begin
				if (c == CH_SLASH) begin
					m    = M_COMMENT;
					done = 1'b1;
				end else begin
					close_now = 1'b1;
				end
			end
			M_COMMENT: begin
				if (c == CH_NL) m = M_IDLE;
				else done = 1'b1;
			end
			M_STRING: begin
				if (c == CH_QUOTE) begin
					tk[n[1:0]] = mk(K_STRING, WIDE_BITS'(b1),
						sub_sat(WIDE_BITS'(p), WIDE_BITS'(b1)), ln);
					n = n + 1'b1;
					m = M_IDLE;
				end else if (c == CH_NL) begin
					ln = line_inc(ln);
				end
				done = 1'b1;
			end
			M_NUMBER: begin
				if (is_digit(c)) begin
					done = 1'b1;
				end else if (c == CH_DOT) begin
					m    = M_NUMDOT;
					done = 1'b1;
				end else begin
					close_now = 1'b1;
				end
			end
			M_NUMDOT: begin
				if (is_digit(c)) begin
					m    = M_FRACTION;
					done = 1'b1;
				end else begin
					close_now = 1'b1;
				end
			end
			M_FRACTION: begin
				if (is_digit(c)) done = 1'b1;
				else close_now = 1'b1;
			end
			M_IDENT: begin
				if (is_alpha(c) || is_digit(c)) done = 1'b1;
				else close_now = 1'b1;
			end
			default: begin
				m = M_IDLE;
			end
		endcase

		// flush the token this byte ends
		if (close_now) begin
			cl = close_tokens(m, b, p, ln);
			if (cl.n != 2'd0) begin
				tk[n[1:0]] = cl.t0;
				n = n + 1'b1;
			end
			if (cl.n == 2'd2) begin
				tk[n[1:0]] = cl.t1;
				n = n + 1'b1;
			end
			m = M_IDLE;
		end

		// start a fresh token with this byte
		if (!done) begin
			b  = p;
			pk = punct_lookup(c);
			if (pk[KIND_BITS]) begin
				tk[n[1:0]] = mk(pk[KIND_BITS-1:0], WIDE_BITS'(p), WIDE_BITS'(1), ln);
				n = n + 1'b1;
			end else begin
				priority if (c == CH_BANG) m = M_BANG;
				else if (c == CH_EQUAL) m = M_EQUAL;
				else if (c == CH_GREATER) m = M_GREATER;
				else if (c == CH_LESS) m = M_LESS;
				else if (c == CH_SLASH) m = M_SLASH;
				else if (c == CH_SPACE || c == CH_CR || c == CH_TAB) m = m;
				else if (c == CH_NL) ln = line_inc(ln);
				else if (c == CH_QUOTE) m = M_STRING;
				else if (is_digit(c)) m = M_NUMBER;
				else if (is_alpha(c)) m = M_IDENT;
				else begin
					tk[n[1:0]] = mk(K_BADCHAR, WIDE_BITS'(p), WIDE_BITS'(1), ln);
					n = n + 1'b1;
				end
			end
		end

		// advance the position, holding at the top
		pn = (p != '1) ? p + 1'b1 : p;

		// end of source: flush, add end token, return to reset values
		if (fin) begin
			cl = close_tokens(m, b, pn, ln);
			if (cl.n != 2'd0) begin
				tk[n[1:0]] = cl.t0;
				n = n + 1'b1;
			end
			if (cl.n == 2'd2) begin
				tk[n[1:0]] = cl.t1;
				n = n + 1'b1;
			end
			tk[n[1:0]] = mk(K_END, WIDE_BITS'(pn), WIDE_BITS'(0), ln);
			n  = n + 1'b1;
			m  = M_IDLE;
			pn = '0;
			b  = '0;
			ln = LINE_BITS'(1);
		end

		mode_d       = m;
		pos_d        = pn;
		begin_d      = b;
		line_d       = ln;
		bundle.count = n;
		bundle.tok   = tk;
	end

	// update scanner state on each accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_IDLE;
			pos_q   <= '0;
			begin_q <= '0;
			line_q  <= LINE_BITS'(1);
		end else if (accept) begin
			mode_q  <= mode_d;
			pos_q   <= pos_d;
			begin_q <= begin_d;
			line_q  <= line_d;
		end
	end

endmodule

// ===== hdl/sbt_queue.sv =====
module sbt_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  sbt_pkg::tok_bundle_t wr_bundle,
	input  logic                 pop,
	output sbt_pkg::tok_bundle_t head,
	output sbt_pkg::q_status_t   q_stat
);
	import sbt_pkg::*;

	localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
	localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

	tok_bundle_t         mem_q [QUEUE_DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [CNT_BITS-1:0] count_q;

	function automatic logic [PTR_BITS-1:0] next_ptr(input logic [PTR_BITS-1:0] p);
		return (p == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign head             = mem_q[rd_ptr_q];
	assign q_stat.full      = (count_q == CNT_BITS'(QUEUE_DEPTH));
	assign q_stat.not_empty = (count_q != '0);

	// store bundles
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wr_bundle;
	end

	// advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= next_ptr(wr_ptr_q);
			if (pop) rd_ptr_q <= next_ptr(rd_ptr_q);
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

endmodule

// ===== hdl/sbt_back.sv =====
module sbt_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sbt_pkg::tok_bundle_t head,
	input  sbt_pkg::q_status_t   q_stat,
	output logic                 pop,
	output logic                 tok_valid,
	input  logic                 tok_stall,
	output sbt_pkg::tok_item_t   tok_item
);
	import sbt_pkg::*;

	localparam int IDX_BITS = $clog2(MAX_TOKENS);

	logic [IDX_BITS-1:0] idx_q;
	logic                last;
	logic                take;

	// walk the head bundle one token per cycle while tok_stall is low
	assign last      = (COUNT_BITS'(idx_q) == head.count - 1'b1);
	assign tok_valid = q_stat.not_empty;
	assign take      = tok_valid && !tok_stall;
	assign pop       = take && last;

	always_comb begin
		tok_item         = head.tok[idx_q];
		tok_item.run_end = last;
	end

	// step the token index, rewind on the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (take) begin
			idx_q <= last ? '0 : idx_q + 1'b1;
		end
	end

endmodule

// ===== hdl/source_byte_tokenizer.sv =====
// Channel   Direction  Handshake             Payload
// src       in         src_valid/src_stall   source_byte, final_byte
// tok       out        tok_valid/tok_stall   kind, start, length, line, run_end
//
// One source byte is taken per cycle while the token queue has room.
// Each byte yields zero to four tokens; they leave one per cycle while
// tok_stall is low, so output port bandwidth sets the rate when bytes
// produce more than one each; tokens are registered in the token queue.
// Reset (arst_n low) returns the scanner to an empty source at line one.
// tok_stall holds the current token; src_stall rises only when the
// four-entry token queue is full.
module source_byte_tokenizer #(
	parameter int POSITION_BITS = 20,
	parameter int LINE_BITS     = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               src_valid,
	output logic               src_stall,
	input  sbt_pkg::src_item_t src_item,
	output logic               tok_valid,
	input  logic               tok_stall,
	output sbt_pkg::tok_item_t tok_item
);
	import sbt_pkg::*;

	tok_bundle_t wr_bundle;
	tok_bundle_t head;
	q_status_t   q_stat;
	logic        push;
	logic        pop;

	sbt_front #(
		.POSITION_BITS(POSITION_BITS),
		.LINE_BITS    (LINE_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.src_valid(src_valid),
		.src_stall(src_stall),
		.src_item (src_item),
		.q_stat   (q_stat),
		.push     (push),
		.bundle   (wr_bundle)
	);

	sbt_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_bundle(wr_bundle),
		.pop      (pop),
		.head     (head),
		.q_stat   (q_stat)
	);

	sbt_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.q_stat   (q_stat),
		.pop      (pop),
		.tok_valid(tok_valid),
		.tok_stall(tok_stall),
		.tok_item (tok_item)
	);

endmodule

// ===== hdl/sbt_checker.sv =====
module sbt_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               src_valid,
	input logic               src_stall,
	input sbt_pkg::src_item_t src_item,
	input logic               tok_valid,
	input logic               tok_stall,
	input sbt_pkg::tok_item_t tok_item
);
	import sbt_pkg::*;

	// hold a stalled source byte
	a_src_hold: assert property (@(posedge clk) disable iff (!arst_n)
		src_valid && src_stall |=> src_valid && $stable(src_item))
		else $error("stalled source item dropped or changed");

	// hold a stalled token
	a_tok_hold: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && tok_stall |=> tok_valid && $stable(tok_item))
		else $error("stalled token dropped or changed");

	// end token always closes its run
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && (tok_item.token_kind == K_END) |-> tok_item.run_end)
		else $error("end token not last of its run");

	// lines count from one
	a_line_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid |-> (tok_item.token_line != '0))
		else $error("token line is zero");

	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid |-> (tok_item.token_kind <= K_UNTERM))
		else $error("token kind out of range");

endmodule

bind source_byte_tokenizer sbt_checker u_sbt_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.src_valid(src_valid),
	.src_stall(src_stall),
	.src_item (src_item),
	.tok_valid(tok_valid),
	.tok_stall(tok_stall),
	.tok_item (tok_item)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
	import sbt_pkg::*;

	localparam int unsigned POS_LIMIT  = (1 << 20) - 1;
	localparam int unsigned LINE_LIMIT = (1 << 16) - 1;
	localparam int TOKENS_PER_BYTE = 5;
	localparam int RANDOM_BYTES    = 400;
	localparam int SETTLE_CYCLES   = 20;
	localparam int IDLE_LIMIT      = 2000;
	localparam int REPORT_LIMIT    = 10;

	typedef struct packed {
		src_item_t item;
		logic      drain_first;
	} feed_entry_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        src_valid = 1'b0;
	logic        src_stall;
	src_item_t   src_item = '0;
	logic        tok_valid;
	logic        tok_stall = 1'b0;
	tok_item_t   tok_item;

	// bytes waiting to be sent and tokens waiting to come back
	feed_entry_t byte_feed[$];
	tok_item_t   expected_tokens[$];
	tok_item_t   step_tokens[$];
	logic [7:0]  source_text[$];

	// scanner state as the block should hold it
	mode_t       scan_mode;
	int unsigned scan_pos;
	int unsigned scan_begin;
	int unsigned scan_line;

	int          mismatches = 0;
	int          idle_cycles = 0;
	int          burst_left;
	int          gap_left;
	int          stall_span;
	int          stall_style;
	feed_entry_t next_entry;

	source_byte_tokenizer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.src_item  (src_item),
		.tok_valid (tok_valid),
		.tok_stall (tok_stall),
		.tok_item  (tok_item)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic digit_char(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic word_start(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_UNDER;
	endfunction

	function automatic int unsigned sat_diff(input int unsigned a, input int unsigned b);
		return a > b ? a - b : 0;
	endfunction

	function automatic logic [KIND_BITS-1:0] operator_kind(input mode_t m);
		case (m)
			M_BANG:    return K_BANG;
			M_EQUAL:   return K_EQUAL;
			M_GREATER: return K_GREATER;
			default:   return K_LESS;
		endcase
	endfunction

	function automatic logic [7:0] pick_from(input string set);
		return set[$urandom_range(0, set.len() - 1)];
	endfunction

	task automatic restart_scan();
		scan_mode  = M_IDLE;
		scan_pos   = 0;
		scan_begin = 0;
		scan_line  = 1;
	endtask

	task automatic bump_line();
		if (scan_line < LINE_LIMIT)
			scan_line++;
	endtask

	// add one byte to the end of the source text being built
	task automatic append_byte(input logic [7:0] c);
		source_text.insert(source_text.size(), c);
	endtask

	// record one token of the current byte, clipped to the port widths
	task automatic note_token(input logic [KIND_BITS-1:0] kind, input int unsigned first,
			input int unsigned count);
		tok_item_t t;
		if (step_tokens.size() >= TOKENS_PER_BYTE)
			return;
		t.token_kind   = kind;
		t.token_start  = first > FIELD_POS_MAX ? FIELD_POS_MAX : FIELD_POS_BITS'(first);
		t.token_length = count > FIELD_POS_MAX ? FIELD_POS_MAX : FIELD_POS_BITS'(count);
		t.token_line   = scan_line > FIELD_LINE_MAX ? FIELD_LINE_MAX
			: FIELD_LINE_BITS'(scan_line);
		t.run_end      = 1'b0;
		step_tokens.insert(step_tokens.size(), t);
	endtask

	// close whatever token is open, as if it ended just before stop_pos
	task automatic flush_pending(input int unsigned stop_pos);
		int unsigned dot_at;
		case (scan_mode)
			M_BANG, M_EQUAL, M_GREATER, M_LESS: note_token(operator_kind(scan_mode), scan_begin, 1);
			M_SLASH: note_token(K_SLASH, scan_begin, 1);
			M_STRING: note_token(K_UNTERM, scan_begin + 1, sat_diff(stop_pos, scan_begin + 1));
			M_NUMBER, M_FRACTION: note_token(K_NUMBER, scan_begin, sat_diff(stop_pos, scan_begin));
			M_NUMDOT: begin
				dot_at = stop_pos > 0 ? stop_pos - 1 : 0;
				note_token(K_NUMBER, scan_begin, sat_diff(dot_at, scan_begin));
				note_token(K_DOT, dot_at, 1);
			end
			M_IDENT: note_token(K_IDENT, scan_begin, sat_diff(stop_pos, scan_begin));
			default: ;
		endcase
		scan_mode = M_IDLE;
	endtask

	// begin a fresh token with byte c at offset p
	task automatic open_token(input logic [7:0] c, input int unsigned p);
		scan_begin = p;
		case (c)
			CH_LPAREN:  note_token(K_LPAREN, p, 1);
			CH_RPAREN:  note_token(K_RPAREN, p, 1);
			CH_LBRACE:  note_token(K_LBRACE, p, 1);
			CH_RBRACE:  note_token(K_RBRACE, p, 1);
			CH_COMMA:   note_token(K_COMMA, p, 1);
			CH_DOT:     note_token(K_DOT, p, 1);
			CH_MINUS:   note_token(K_MINUS, p, 1);
			CH_PLUS:    note_token(K_PLUS, p, 1);
			CH_SEMI:    note_token(K_SEMICOLON, p, 1);
			CH_STAR:    note_token(K_STAR, p, 1);
			CH_BANG:    scan_mode = M_BANG;
			CH_EQUAL:   scan_mode = M_EQUAL;
			CH_GREATER: scan_mode = M_GREATER;
			CH_LESS:    scan_mode = M_LESS;
			CH_SLASH:   scan_mode = M_SLASH;
			CH_SPACE, CH_CR, CH_TAB: ;
			CH_NL:      bump_line();
			CH_QUOTE:   scan_mode = M_STRING;
			default: begin
				if (digit_char(c))
					scan_mode = M_NUMBER;
				else if (word_start(c))
					scan_mode = M_IDENT;
				else
					note_token(K_BADCHAR, p, 1);
			end
		endcase
	endtask

	// advance the scanner by one accepted byte and queue the tokens it yields
	task automatic tokenize(input src_item_t it);
		logic [7:0]  c;
		int unsigned p;
		logic        taken;
		c = it.source_byte;
		p = scan_pos;
		taken = 1'b0;
		step_tokens.delete();
		case (scan_mode)
			M_BANG, M_EQUAL, M_GREATER, M_LESS: begin
				if (c == CH_EQUAL) begin
					note_token(operator_kind(scan_mode) + K_PAIR_STEP, scan_begin, 2);
					scan_mode = M_IDLE;
					taken = 1'b1;
				end else flush_pending(p);
			end
			M_SLASH: begin
				if (c == CH_SLASH) begin
					scan_mode = M_COMMENT;
					taken = 1'b1;
				end else flush_pending(p);
			end
			M_COMMENT: begin
				if (c == CH_NL)
					scan_mode = M_IDLE;
				else
					taken = 1'b1;
			end
			M_STRING: begin
				if (c == CH_QUOTE) begin
					note_token(K_STRING, scan_begin + 1, sat_diff(p, scan_begin + 1));
					scan_mode = M_IDLE;
				end else if (c == CH_NL) begin
					bump_line();
				end
				taken = 1'b1;
			end
			M_NUMBER: begin
				if (digit_char(c)) begin
					taken = 1'b1;
				end else if (c == CH_DOT) begin
					scan_mode = M_NUMDOT;
					taken = 1'b1;
				end else flush_pending(p);
			end
			M_NUMDOT: begin
				if (digit_char(c)) begin
					scan_mode = M_FRACTION;
					taken = 1'b1;
				end else flush_pending(p);
			end
			M_FRACTION: begin
				if (digit_char(c))
					taken = 1'b1;
				else
					flush_pending(p);
			end
			M_IDENT: begin
				if (word_start(c) || digit_char(c))
					taken = 1'b1;
				else
					flush_pending(p);
			end
			default: scan_mode = M_IDLE;
		endcase
		if (!taken)
			open_token(c, p);
		if (p < POS_LIMIT)
			scan_pos = p + 1;
		// end of source: close the open token, add the end token, start over
		if (it.final_byte) begin
			flush_pending(scan_pos);
			note_token(K_END, scan_pos, 0);
			restart_scan();
		end
		if (step_tokens.size() > 0)
			step_tokens[step_tokens.size() - 1].run_end = 1'b1;
		foreach (step_tokens[i])
			expected_tokens.insert(expected_tokens.size(), step_tokens[i]);
	endtask

	// move the built source text into the feed, final flag on its last byte
	task automatic queue_source(input logic drain_first);
		feed_entry_t e;
		foreach (source_text[i]) begin
			e.item.source_byte = source_text[i];
			e.item.final_byte  = (i == source_text.size() - 1);
			e.drain_first      = drain_first && (i == 0);
			byte_feed.insert(byte_feed.size(), e);
		end
		source_text.delete();
	endtask

	// append one random lexeme, well formed most of the time
	task automatic add_lexeme();
		case ($urandom_range(0, 9))
			0, 1: begin
				append_byte(pick_from("abcxyzABCXYZ_"));
				repeat ($urandom_range(0, 6))
					append_byte(pick_from("abqzAQZ_0579"));
			end
			2: begin
				repeat ($urandom_range(1, 4))
					append_byte(pick_from("0123456789"));
				case ($urandom_range(0, 3))
					0: begin
						append_byte(CH_DOT);
						repeat ($urandom_range(1, 3))
							append_byte(pick_from("0123456789"));
					end
					1: append_byte(CH_DOT);
					default: ;
				endcase
			end
			3: begin
				append_byte(CH_QUOTE);
				repeat ($urandom_range(0, 6))
					append_byte($urandom_range(0, 5) == 0 ? CH_NL
						: pick_from("ab z09(+=/.!*"));
				append_byte(CH_QUOTE);
			end
			4: begin
				append_byte(pick_from("!=<>"));
				if ($urandom_range(0, 1) == 1)
					append_byte(CH_EQUAL);
			end
			5: append_byte(pick_from("(){},.-+;*/"));
			6: begin
				append_byte(CH_SLASH);
				append_byte(CH_SLASH);
				repeat ($urandom_range(0, 5))
					append_byte(pick_from("ab z\"09(/"));
				append_byte(CH_NL);
			end
			7: begin
				case ($urandom_range(0, 3))
					0: append_byte(CH_SPACE);
					1: append_byte(CH_TAB);
					2: append_byte(CH_CR);
					default: append_byte(CH_NL);
				endcase
			end
			8: append_byte(8'($urandom_range(0, 255)));
			default: append_byte(8'($urandom_range(128, 255)));
		endcase
		if ($urandom_range(0, 1) == 1)
			append_byte($urandom_range(0, 3) == 0 ? CH_NL : CH_SPACE);
	endtask

	// compare one token from the block with the oldest expectation
	task automatic check_token(input tok_item_t got);
		tok_item_t want;
		if (expected_tokens.size() == 0) begin
			mismatches++;
			if (mismatches <= REPORT_LIMIT)
				$display("%0t: token with none expected: kind %0d start %0d len %0d line %0d",
					$realtime, got.token_kind, got.token_start, got.token_length,
					got.token_line);
			return;
		end
		want = expected_tokens.pop_front();
		if (got.token_kind !== want.token_kind || got.token_start !== want.token_start
				|| got.token_length !== want.token_length
				|| got.token_line !== want.token_line || got.run_end !== want.run_end) begin
			mismatches++;
			if (mismatches <= REPORT_LIMIT) begin
				$display("%0t: token mismatch", $realtime);
				$display("  expected kind %0d start %0d len %0d line %0d last %0b",
					want.token_kind, want.token_start, want.token_length, want.token_line,
					want.run_end);
				$display("  actual   kind %0d start %0d len %0d line %0d last %0b",
					got.token_kind, got.token_start, got.token_length, got.token_line,
					got.run_end);
			end
		end
	endtask

	// sender: bursts and gaps, hold while stalled, predict on every accepted item
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_valid  <= 1'b0;
			src_item   <= '0;
			burst_left = $urandom_range(1, 40);
			gap_left   = 0;
			restart_scan();
		end else begin
			if (src_valid && !src_stall)
				tokenize(src_item);
			if (!(src_valid && src_stall)) begin
				if (gap_left > 0) begin
					gap_left--;
					src_valid <= 1'b0;
				end else if (byte_feed.size() == 0) begin
					src_valid <= 1'b0;
				end else if (byte_feed[0].drain_first && expected_tokens.size() != 0) begin
					src_valid <= 1'b0;
				end else begin
					next_entry = byte_feed.pop_front();
					src_item  <= next_entry.item;
					src_valid <= 1'b1;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 40);
						gap_left   = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 8);
					end
				end
			end
		end
	end

	// receiver: check accepted tokens, stall in spans of varying density
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_stall   <= 1'b0;
			stall_span  = 0;
			stall_style = 0;
		end else begin
			if (tok_valid && !tok_stall)
				check_token(tok_item);
			if (stall_span == 0) begin
				stall_style = $urandom_range(0, 3);
				stall_span  = $urandom_range(5, 40);
			end
			stall_span--;
			case (stall_style)
				0: tok_stall <= 1'b0;
				1: tok_stall <= $urandom_range(0, 9) < 3;
				2: tok_stall <= $urandom_range(0, 9) < 7;
				default: tok_stall <= 1'b1;
			endcase
		end
	end

	// watchdog: end the run when no item moves on either side for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((src_valid && !src_stall) || (tok_valid && !tok_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("watchdog: no item moved for %0d cycles", IDLE_LIMIT);
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	initial begin
		string opening;
		int base;

		// operators, slashes, fraction, dot without digit, multi-line string,
		// bad bytes at both ends of the range, source ending inside a string
		opening = "!=</</c\n7.5.;3.)\"\n\"x";
		for (int i = 0; i < opening.len(); i++)
			append_byte(opening[i]);
		append_byte(8'hFF);
		append_byte(8'h00);
		append_byte(CH_QUOTE);
		append_byte("q");
		queue_source(1'b0);
		// one-byte sources: a high bad byte, then a lone pending operator
		append_byte(8'h80);
		queue_source(1'b1);
		append_byte(CH_GREATER);
		queue_source(1'b0);

		// random sources, some ending inside a string, some waiting for a drain
		base = byte_feed.size();
		while (byte_feed.size() - base < RANDOM_BYTES) begin
			repeat ($urandom_range(1, 10))
				add_lexeme();
			if ($urandom_range(0, 5) == 0) begin
				append_byte(CH_QUOTE);
				repeat ($urandom_range(0, 3))
					append_byte(pick_from("ab9 "));
			end
			queue_source(byte_feed.size() == base || $urandom_range(0, 5) == 0);
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		while (byte_feed.size() != 0 || src_valid || expected_tokens.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (mismatches == 0 && expected_tokens.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
